@@ design/mf_pkg.sv @@
package mf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int WINDOW     = 3;
  localparam int WIN_N      = WINDOW * WINDOW;
  localparam int MID        = WIN_N / 2;
  localparam int SORT_CELLS = (WIN_N + 1) / 2;

  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);
  localparam int OROW_W     = $clog2(MAX_HEIGHT);
  localparam int EW_W       = $clog2(MAX_WIDTH + 1);
  localparam int EH_W       = $clog2(MAX_HEIGHT + 1);

  localparam int CFG_WD_W   = 11;
  localparam int CFG_HT_W   = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef struct packed {
    pix_t [WIN_N-1:0] px;
    logic             eof;
  } win_t;

  typedef struct packed {
    logic emit;
    logic eof;
    logic r_first;
    logic r_last;
    logic c_first;
    logic c_last;
    logic bank;
  } step_t;

endpackage

@@ design/mf_line_store.sv @@
module mf_line_store import mf_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic             rd_en,
  input  logic [COL_W-1:0] addr,
  input  pix_t             wr_data,
  output pix_t             rd_data
);

  pix_t mem [MAX_WIDTH];
  pix_t rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/mf_sort_cell.sv @@
module mf_sort_cell import mf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  win_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output win_t dn_data
);

  logic             v_r;
  win_t             data_r;
  win_t             data_nxt;
  pix_t [WIN_N-1:0] ev;
  pix_t [WIN_N-1:0] od;

  // one even and one odd compare-exchange pass
  always_comb begin
    ev = up_data.px;
    for (int i = 0; i + 1 < WIN_N; i += 2) begin
      if (up_data.px[i] > up_data.px[i+1]) begin
        ev[i]   = up_data.px[i+1];
        ev[i+1] = up_data.px[i];
      end
    end
    od = ev;
    for (int i = 1; i + 1 < WIN_N; i += 2) begin
      if (ev[i] > ev[i+1]) begin
        od[i]   = ev[i+1];
        od[i+1] = ev[i];
      end
    end
    data_nxt.px  = od;
    data_nxt.eof = up_data.eof;
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = data_r;

endmodule

@@ design/mf_window.sv @@
module mf_window import mf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [PIX_W-1:0]      in_pixel,
  output logic                  win_valid,
  input  logic                  win_ready,
  output win_t                  win_data
);

  logic [CFG_WD_W-1:0] width_r;
  logic [CFG_HT_W-1:0] height_r;
  logic [EW_W-1:0]     w_eff;
  logic [EH_W-1:0]     h_eff;
  logic [COL_W-1:0]    w_last;
  logic [OROW_W-1:0]   h_last;

  logic [COL_W-1:0]    in_col_r, in_col_nxt;
  logic [ROW_W-1:0]    in_row_r, in_row_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic [OROW_W-1:0]   out_row_r, out_row_nxt;
  logic                done_r, done_nxt;
  logic                fill_r, fill_nxt;

  logic                s1_v_r;
  step_t               s1_step_r;
  pix_t                s1_px_r;
  col_t                colb_r;
  col_t                colc_r;
  logic                win_v_r;
  win_t                win_r;

  logic                restart;
  logic                in_fire;
  logic                live_push;
  logic                live_drain;
  logic                step_go;
  logic                step_emit;
  logic                col_wrap;
  logic                res_r_first, res_r_last, res_c_first, res_c_last, res_eof;
  logic                s1_adv;
  logic                s1_take;
  logic                win_take;
  pix_t                rd0, rd1;
  col_t                col_a;
  col_t                left_c, mid_c, right_c;
  win_t                win_nxt;

  function automatic col_t clamp_rows(col_t c, logic first, logic last);
    col_t o;
    o = c;
    if (first) o.top = c.mid;
    if (last)  o.bot = c.mid;
    return o;
  endfunction

  always_comb begin
    if (width_r == '0) begin
      w_eff = EW_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_eff = EW_W'(MAX_WIDTH);
    end else begin
      w_eff = EW_W'(width_r);
    end
    if (height_r == '0) begin
      h_eff = EH_W'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      h_eff = EH_W'(MAX_HEIGHT);
    end else begin
      h_eff = EH_W'(height_r);
    end
    w_last = COL_W'(w_eff - EW_W'(1));
    h_last = OROW_W'(h_eff - EH_W'(1));
  end

  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_WD_W'(MAX_WIDTH);
      height_r <= CFG_HT_W'(MAX_HEIGHT);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[CFG_WD_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[CFG_HT_W-1:0];
        default: ;
      endcase
    end
  end

  assign win_take = !win_v_r || win_ready;
  assign s1_adv   = s1_v_r && (!s1_step_r.emit || win_take);
  assign s1_take  = !s1_v_r || s1_adv;
  assign in_ready = s1_take && !fill_r;

  assign in_fire    = in_valid && in_ready;
  assign live_push  = in_fire && in_command == CMD_PUSH && !done_r;
  assign live_drain = in_fire && in_command == CMD_DRAIN && done_r;
  assign step_go    = live_push || live_drain || (fill_r && s1_take);
  assign step_emit  = live_drain || (live_push && (in_row_r > ROW_W'(1) ||
                      (in_row_r == ROW_W'(1) && in_col_r != '0)));

  assign col_wrap    = in_col_r == w_last;
  assign res_r_first = out_row_r == '0;
  assign res_r_last  = out_row_r == h_last;
  assign res_c_first = out_col_r == '0;
  assign res_c_last  = out_col_r == w_last;
  assign res_eof     = res_r_last && res_c_last;

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    done_nxt    = done_r;
    fill_nxt    = fill_r;
    if (step_go) begin
      if (col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
      if (live_push && col_wrap && in_row_r == ROW_W'(h_last)) begin
        done_nxt = 1'b1;
        fill_nxt = h_last == '0;
      end
      if (fill_r) begin
        fill_nxt = 1'b0;
      end
      if (step_emit) begin
        if (res_eof) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
          done_nxt    = 1'b0;
        end else if (res_c_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + OROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
    if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      done_nxt    = 1'b0;
      fill_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      done_r    <= 1'b0;
      fill_r    <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      done_r    <= done_nxt;
      fill_r    <= fill_nxt;
    end
  end

  // row iy-2 sits in bank iy%2 and is read before the new pixel replaces it
  mf_line_store u_bank0 (
    .clk     (clk),
    .wr_en   (live_push && !in_row_r[0]),
    .rd_en   (step_go),
    .addr    (in_col_r),
    .wr_data (in_pixel),
    .rd_data (rd0)
  );

  mf_line_store u_bank1 (
    .clk     (clk),
    .wr_en   (live_push && in_row_r[0]),
    .rd_en   (step_go),
    .addr    (in_col_r),
    .wr_data (in_pixel),
    .rd_data (rd1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (step_go) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      s1_step_r.emit    <= step_emit;
      s1_step_r.eof     <= res_eof;
      s1_step_r.r_first <= res_r_first;
      s1_step_r.r_last  <= res_r_last;
      s1_step_r.c_first <= res_c_first;
      s1_step_r.c_last  <= res_c_last;
      s1_step_r.bank    <= in_row_r[0];
      s1_px_r           <= in_pixel;
    end
  end

  always_comb begin
    col_a.top = s1_step_r.bank ? rd1 : rd0;
    col_a.mid = s1_step_r.bank ? rd0 : rd1;
    col_a.bot = s1_px_r;
    left_c  = clamp_rows(s1_step_r.c_first ? colb_r : colc_r,
                         s1_step_r.r_first, s1_step_r.r_last);
    mid_c   = clamp_rows(colb_r, s1_step_r.r_first, s1_step_r.r_last);
    right_c = clamp_rows(s1_step_r.c_last ? colb_r : col_a,
                         s1_step_r.r_first, s1_step_r.r_last);
    win_nxt.px[0] = left_c.top;
    win_nxt.px[1] = left_c.mid;
    win_nxt.px[2] = left_c.bot;
    win_nxt.px[3] = mid_c.top;
    win_nxt.px[4] = mid_c.mid;
    win_nxt.px[5] = mid_c.bot;
    win_nxt.px[6] = right_c.top;
    win_nxt.px[7] = right_c.mid;
    win_nxt.px[8] = right_c.bot;
    win_nxt.eof   = s1_step_r.eof;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      colb_r <= col_a;
      colc_r <= colb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_v_r <= 1'b0;
    end else if (win_take) begin
      win_v_r <= s1_adv && s1_step_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (win_take && s1_adv && s1_step_r.emit) begin
      win_r <= win_nxt;
    end
  end

  assign win_valid = win_v_r;
  assign win_data  = win_r;

endmodule

@@ design/median_filter_3x3_top.sv @@
// throughput: one input beat and one result beat per clock unless out_ready
//   stalls the chain, bounded by the single read of both line stores per beat
// path: a result leaves through the window stage and five sort cells after
//   the input beat that releases it; in raster terms one row plus one pixel
// a one-row frame takes one extra internal step after its last pixel, with in_ready low
// reset: synchronous active low, clears positions and flags, width 1024, height 4096
module median_filter_3x3_top import mf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [PIX_W-1:0]      in_pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      out_median_value,
  output logic                  out_end_of_frame
);

  logic [SORT_CELLS:0] c_valid;
  logic [SORT_CELLS:0] c_ready;
  win_t                c_data [SORT_CELLS+1];

  mf_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_pixel   (in_pixel),
    .win_valid  (c_valid[0]),
    .win_ready  (c_ready[0]),
    .win_data   (c_data[0])
  );

  for (genvar g = 0; g < SORT_CELLS; g++) begin : g_cell
    mf_sort_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_valid[g]),
      .up_ready (c_ready[g]),
      .up_data  (c_data[g]),
      .dn_valid (c_valid[g+1]),
      .dn_ready (c_ready[g+1]),
      .dn_data  (c_data[g+1])
    );
  end

  assign c_ready[SORT_CELLS] = out_ready;
  assign out_valid           = c_valid[SORT_CELLS];
  assign out_median_value    = c_data[SORT_CELLS].px[MID];
  assign out_end_of_frame    = c_data[SORT_CELLS].eof;

  function automatic logic is_sorted(win_t w);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i + 1 < WIN_N; i++) begin
      if (w.px[i] > w.px[i+1]) ok = 1'b0;
    end
    return ok;
  endfunction

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> is_sorted(c_data[SORT_CELLS]))
    else $error("sort chain output not ordered");

  a_chain_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> c_ready[0])
    else $error("sort chain blocks window with empty output");

  a_window_beat: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid[0] && c_ready[0] |=> c_valid[1])
    else $error("window beat lost entering sort chain");

endmodule
